@@ rtl/mexp_pkg.sv @@
package mexp_pkg;

   localparam int WORD_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;

   typedef logic [WORD_WIDTH-1:0] word_type;
   typedef logic [CSR_ADDR_WIDTH-1:0] csr_addr_type;

   // byte address of the modulus register
   localparam csr_addr_type ADDR_MODULUS = csr_addr_type'(0);

   localparam word_type MODULUS_RESET = word_type'(1);

endpackage

@@ rtl/modular_exponentiation.sv @@
// sequence: base reduction, then per exponent bit up to the highest set one a
// modular multiply (bit set) and a squaring (all but the top bit), each on
// the one shared shift-add-reduce unit; a zero exponent skips the unit.
// one item at a time; the next item is taken while the result waits in rsp.
// reset (synchronous) clears the sequencer and sets the modulus to 1.
module modular_exponentiation
   import mexp_pkg::*;
#(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  word_type     req_base_value,
   input  word_type     req_exponent,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output word_type     rsp_power_result,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  csr_addr_type csr_paddr,
   input  word_type     csr_pwdata,
   output word_type     csr_prdata,
   output logic         csr_pready
);

   localparam int W = OPERAND_WIDTH;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_SQR    = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]   state_ff, state_in;
   logic         start_ff, start_in;
   logic         rsp_valid_ff, rsp_valid_in;
   word_type     rsp_data_ff, rsp_data_in;
   word_type     modulus_ff, modulus_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [W-1:0] base_ff, base_in;
   logic [W-1:0] exp_ff, exp_in;

   logic [W:0]   mod_eff;
   logic [W-1:0] unit_x;
   logic [W-1:0] unit_y;
   logic         unit_done;
   logic [W-1:0] unit_product;
   logic [W-1:0] exp_shift;
   logic         csr_write;

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_MODULUS) ? modulus_ff : word_type'(0);

   // a zero modulus acts as 2^W, which keeps the low W bits
   assign mod_eff = {modulus_ff[W-1:0] == '0, modulus_ff[W-1:0]};

   assign unit_x = (state_ff == ST_MUL) ? acc_ff : base_ff;
   assign unit_y = (state_ff == ST_REDUCE) ? W'(1) : base_ff;
   assign exp_shift = exp_ff >> 1;

   mexp_mulmod #(
      .OPERAND_WIDTH(W)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .x_value (unit_x),
      .y_value (unit_y),
      .modulus (mod_eff),
      .done    (unit_done),
      .product (unit_product)
   );

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      start_in = 1'b0;
      acc_in = acc_ff;
      base_in = base_ff;
      exp_in = exp_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      modulus_in = modulus_ff;
      if (csr_write && csr_paddr == ADDR_MODULUS) begin
         modulus_in = csr_pwdata;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               acc_in = W'(1);
               base_in = req_base_value[W-1:0];
               exp_in = req_exponent[W-1:0];
               if (req_exponent[W-1:0] == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_REDUCE;
                  start_in = 1'b1;
               end
            end
         end
         ST_REDUCE, ST_SQR: begin
            if (unit_done) begin
               base_in = unit_product;
               start_in = 1'b1;
               if (exp_ff[0]) begin
                  state_in = ST_MUL;
               end else begin
                  // bit is clear and higher bits remain: square again
                  exp_in = exp_shift;
                  state_in = ST_SQR;
               end
            end
         end
         ST_MUL: begin
            if (unit_done) begin
               acc_in = unit_product;
               exp_in = exp_shift;
               if (exp_shift == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SQR;
                  start_in = 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = word_type'(acc_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         modulus_ff <= MODULUS_RESET;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         modulus_ff <= modulus_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      base_ff <= base_in;
      exp_ff <= exp_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_power_result = rsp_data_ff;

endmodule

@@ rtl/mexp_mulmod.sv @@
module mexp_mulmod #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [OPERAND_WIDTH-1:0] x_value,
   input  logic [OPERAND_WIDTH-1:0] y_value,
   input  logic [OPERAND_WIDTH:0]   modulus,
   output logic                     done,
   output logic [OPERAND_WIDTH-1:0] product
);

   localparam int W = OPERAND_WIDTH;
   localparam int TW = W + 3;
   localparam int CW = (W > 1) ? $clog2(W) : 1;
   localparam logic [CW-1:0] LAST_STEP = CW'(W - 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  y_ff, y_in;
   logic [W-1:0]  r_ff, r_in;

   logic [TW-1:0] sum;
   logic [TW-1:0] diff_one;
   logic [TW-1:0] diff_two;
   logic [W-1:0]  r_step;

   // r stays below m, so 2r + y stays below 3m: subtract 0, m or 2m
   always_comb begin
      sum = TW'({r_ff, 1'b0}) + (x_ff[W-1] ? TW'(y_ff) : TW'(0));
      diff_one = sum - TW'(modulus);
      diff_two = sum - TW'({modulus, 1'b0});
      priority if (!diff_two[TW-1]) begin
         r_step = diff_two[W-1:0];
      end else if (!diff_one[TW-1]) begin
         r_step = diff_one[W-1:0];
      end else begin
         r_step = sum[W-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      x_in = x_ff;
      y_in = y_ff;
      r_in = r_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         x_in = x_value;
         y_in = y_value;
         r_in = '0;
      end else if (busy_ff) begin
         r_in = r_step;
         x_in = {x_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      r_ff <= r_in;
   end

   assign done = done_ff;
   assign product = r_ff;

endmodule
